// ----- src/runge_kutta_stage_combiner_top_defines.svh -----
// assertion macros shared by the stage combiner rtl
`ifndef RUNGE_KUTTA_STAGE_COMBINER_TOP_DEFINES_SVH
`define RUNGE_KUTTA_STAGE_COMBINER_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define RKSC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define RKSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/rksc_pkg.sv -----
// types, constants, microcode rom and butcher tables of the stage combiner
`default_nettype none

package rksc_pkg;

    // default sizes
    localparam int DEF_MAX_ELEMENTS = 1024;
    localparam int DEF_MAX_STAGES   = 4;
    localparam int DEF_FRAC_BITS    = 16;

    // fixed widths
    localparam int IDX_W     = 10;
    localparam int VAL_W     = 32;
    localparam int DT_W      = 31;
    localparam int STAT_W    = 2;
    localparam int SNUM_W    = 3;
    localparam int METH_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = 66;
    localparam int COEF_FRAC = 28;
    localparam int UPC_W     = 4;

    // method codes
    localparam logic [METH_W-1:0] M_FEULER = 4'd0;
    localparam logic [METH_W-1:0] M_EMID   = 4'd1;
    localparam logic [METH_W-1:0] M_HEUN   = 4'd2;
    localparam logic [METH_W-1:0] M_KUTTA3 = 4'd3;
    localparam logic [METH_W-1:0] M_HEUN3  = 4'd4;
    localparam logic [METH_W-1:0] M_SSPRK3 = 4'd5;
    localparam logic [METH_W-1:0] M_RK4    = 4'd6;
    localparam logic [METH_W-1:0] M_BEULER = 4'd7;
    localparam logic [METH_W-1:0] M_IMID   = 4'd8;
    localparam logic [METH_W-1:0] M_CN     = 4'd9;
    localparam logic [METH_W-1:0] M_KS2    = 4'd10;
    localparam logic [METH_W-1:0] M_QZ2    = 4'd11;
    localparam logic [METH_W-1:0] M_ALX2   = 4'd12;
    localparam logic [METH_W-1:0] M_RK43   = 4'd13;

    // opcodes, status codes, register indexes
    localparam logic OP_STAGE = 1'b0;
    localparam logic OP_FINAL = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_ALL_DONE   = 2'd1;
    localparam logic [STAT_W-1:0] ST_INCOMPLETE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_METHOD     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECIP_STEP = 2'd2;

    // tableau coefficients, 28 fraction bits
    localparam logic signed [31:0] K_ONE     = 32'sd268435456;
    localparam logic signed [31:0] K_HALF    = 32'sd134217728;
    localparam logic signed [31:0] K_QTR     = 32'sd67108864;
    localparam logic signed [31:0] K_3QTR    = 32'sd201326592;
    localparam logic signed [31:0] K_3HALF   = 32'sd402653184;
    localparam logic signed [31:0] K_TWO     = 32'sd536870912;
    localparam logic signed [31:0] K_SIXTH   = 32'sd44739243;
    localparam logic signed [31:0] K_THIRD   = 32'sd89478485;
    localparam logic signed [31:0] K_2THIRD  = 32'sd178956971;
    localparam logic signed [31:0] K_GAMMA   = 32'sd78622925;
    localparam logic signed [31:0] K_1MGAMMA = 32'sd189812531;

    // saturation bounds on the wide datapath
    localparam logic signed [PROD_W-1:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [PROD_W-1:0] SAT_LO = -66'sd2147483648;

    // beats
    typedef struct packed {
        logic                    opcode;
        logic [IDX_W-1:0]        element_index;
        logic signed [VAL_W-1:0] new_value;
        logic signed [VAL_W-1:0] old_value;
        logic                    last_element;
    } t_in_beat;

    typedef struct packed {
        logic signed [VAL_W-1:0] updated_value;
        logic signed [VAL_W-1:0] stage_slope;
        logic [STAT_W-1:0]       status;
        logic [SNUM_W-1:0]       stage_number;
    } t_out_beat;

    // multiplier operand selection
    typedef enum logic [1:0] {
        MOP_NONE,
        MOP_SLOPE,
        MOP_COEF,
        MOP_DT
    } t_mop;

    // jump conditions
    typedef enum logic [2:0] {
        C_NONE,
        C_NO_ITEM,
        C_BAD,
        C_MORE,
        C_OUT_BUSY
    } t_cond;

    // microprogram addresses
    localparam logic [UPC_W-1:0] U_IDLE  = 4'd0;
    localparam logic [UPC_W-1:0] U_CHECK = 4'd1;
    localparam logic [UPC_W-1:0] U_SLOPE = 4'd2;
    localparam logic [UPC_W-1:0] U_READ  = 4'd3;
    localparam logic [UPC_W-1:0] U_MUL   = 4'd4;
    localparam logic [UPC_W-1:0] U_ACC   = 4'd5;
    localparam logic [UPC_W-1:0] U_SCALE = 4'd6;
    localparam logic [UPC_W-1:0] U_DONE  = 4'd7;
    localparam logic [UPC_W-1:0] U_ERR   = 4'd8;

    // one control word
    typedef struct packed {
        logic             take;
        t_mop             mop;
        logic             init;
        logic             wr_slope;
        logic             rd;
        logic             acc;
        logic             emit;
        t_cond            cond;
        logic [UPC_W-1:0] target;
        logic             to_idle;
    } t_uword;

    // sequencer condition inputs
    typedef struct packed {
        logic item;
        logic bad;
        logic more;
        logic out_busy;
    } t_cond_in;

    // datapath status toward the top level
    typedef struct packed {
        logic              bad;
        logic              more;
        logic [STAT_W-1:0] status;
    } t_dp_stat;

    // microprogram
    function automatic t_uword ucode_rom(input logic [UPC_W-1:0] pc);
        t_uword w;
        w = '0;
        unique case (pc)
            U_IDLE: begin
                w.take   = 1'b1;
                w.cond   = C_NO_ITEM;
                w.target = U_IDLE;
            end
            U_CHECK: begin
                w.init   = 1'b1;
                w.mop    = MOP_SLOPE;
                w.cond   = C_BAD;
                w.target = U_ERR;
            end
            U_SLOPE: begin
                w.wr_slope = 1'b1;
            end
            U_READ: begin
                w.rd = 1'b1;
            end
            U_MUL: begin
                w.mop = MOP_COEF;
            end
            U_ACC: begin
                w.acc    = 1'b1;
                w.cond   = C_MORE;
                w.target = U_READ;
            end
            U_SCALE: begin
                w.mop = MOP_DT;
            end
            U_DONE: begin
                w.emit    = 1'b1;
                w.cond    = C_OUT_BUSY;
                w.target  = U_DONE;
                w.to_idle = 1'b1;
            end
            U_ERR: begin
                w.emit    = 1'b1;
                w.cond    = C_OUT_BUSY;
                w.target  = U_ERR;
                w.to_idle = 1'b1;
            end
            default: begin
                w.to_idle = 1'b1;
            end
        endcase
        return w;
    endfunction

    // stage count of each method
    function automatic logic [SNUM_W-1:0] method_stages(input logic [METH_W-1:0] m);
        logic [SNUM_W-1:0] n;
        unique case (m) inside
            M_EMID, M_HEUN, M_CN, M_KS2, M_QZ2, M_ALX2: n = 3'd2;
            M_KUTTA3, M_HEUN3, M_SSPRK3:                n = 3'd3;
            M_RK4, M_RK43:                              n = 3'd4;
            default:                                    n = 3'd1;
        endcase
        return n;
    endfunction

    // stage matrix a(r, c)
    function automatic logic signed [31:0] a_coef(input logic [METH_W-1:0] m,
                                                  input logic [1:0] r,
                                                  input logic [1:0] c);
        logic signed [31:0] v;
        v = '0;
        case (m)
            M_EMID:   if (r == 2'd1 && c == 2'd0) v = K_HALF;
            M_HEUN:   if (r == 2'd1 && c == 2'd0) v = K_ONE;
            M_KUTTA3: begin
                if (r == 2'd1 && c == 2'd0) v = K_HALF;
                if (r == 2'd2 && c == 2'd0) v = -K_ONE;
                if (r == 2'd2 && c == 2'd1) v = K_TWO;
            end
            M_HEUN3: begin
                if (r == 2'd1 && c == 2'd0) v = K_THIRD;
                if (r == 2'd2 && c == 2'd1) v = K_2THIRD;
            end
            M_SSPRK3: begin
                if (r == 2'd1 && c == 2'd0) v = K_ONE;
                if (r == 2'd2 && c == 2'd0) v = K_QTR;
                if (r == 2'd2 && c == 2'd1) v = K_QTR;
            end
            M_RK4: begin
                if (r == 2'd1 && c == 2'd0) v = K_HALF;
                if (r == 2'd2 && c == 2'd1) v = K_HALF;
                if (r == 2'd3 && c == 2'd2) v = K_ONE;
            end
            M_BEULER: if (r == 2'd0 && c == 2'd0) v = K_ONE;
            M_IMID:   if (r == 2'd0 && c == 2'd0) v = K_HALF;
            M_CN: begin
                if (r == 2'd1 && c == 2'd0) v = K_HALF;
                if (r == 2'd1 && c == 2'd1) v = K_HALF;
            end
            M_KS2: begin
                if (r == 2'd0 && c == 2'd0) v = K_HALF;
                if (r == 2'd1 && c == 2'd0) v = -K_HALF;
                if (r == 2'd1 && c == 2'd1) v = K_TWO;
            end
            M_QZ2: begin
                if (r == 2'd0 && c == 2'd0) v = K_QTR;
                if (r == 2'd1 && c == 2'd0) v = K_HALF;
                if (r == 2'd1 && c == 2'd1) v = K_QTR;
            end
            M_ALX2: begin
                if (r == 2'd0 && c == 2'd0) v = K_GAMMA;
                if (r == 2'd1 && c == 2'd0) v = K_1MGAMMA;
                if (r == 2'd1 && c == 2'd1) v = K_GAMMA;
            end
            M_RK43: begin
                if (r == 2'd0 && c == 2'd0) v = K_HALF;
                if (r == 2'd1 && c == 2'd0) v = K_SIXTH;
                if (r == 2'd1 && c == 2'd1) v = K_HALF;
                if (r == 2'd2 && c == 2'd0) v = -K_HALF;
                if (r == 2'd2 && c == 2'd1) v = K_HALF;
                if (r == 2'd2 && c == 2'd2) v = K_HALF;
                if (r == 2'd3 && c == 2'd0) v = K_3HALF;
                if (r == 2'd3 && c == 2'd1) v = -K_3HALF;
                if (r == 2'd3 && c == 2'd2) v = K_HALF;
                if (r == 2'd3 && c == 2'd3) v = K_HALF;
            end
            default: v = '0;
        endcase
        return v;
    endfunction

    // final weights b(c)
    function automatic logic signed [31:0] b_coef(input logic [METH_W-1:0] m,
                                                  input logic [1:0] c);
        logic signed [31:0] v;
        v = '0;
        case (m) inside
            M_EMID:   if (c == 2'd1) v = K_ONE;
            M_HEUN, M_CN, M_QZ2: begin
                if (c == 2'd0 || c == 2'd1) v = K_HALF;
            end
            M_KUTTA3: begin
                if (c == 2'd0 || c == 2'd2) v = K_SIXTH;
                if (c == 2'd1) v = K_2THIRD;
            end
            M_HEUN3: begin
                if (c == 2'd0) v = K_QTR;
                if (c == 2'd2) v = K_3QTR;
            end
            M_SSPRK3: begin
                if (c == 2'd0 || c == 2'd1) v = K_SIXTH;
                if (c == 2'd2) v = K_2THIRD;
            end
            M_RK4: begin
                if (c == 2'd0 || c == 2'd3) v = K_SIXTH;
                if (c == 2'd1 || c == 2'd2) v = K_THIRD;
            end
            M_KS2: begin
                if (c == 2'd0) v = -K_HALF;
                if (c == 2'd1) v = K_3HALF;
            end
            M_ALX2: begin
                if (c == 2'd0) v = K_1MGAMMA;
                if (c == 2'd1) v = K_GAMMA;
            end
            M_RK43: begin
                if (c == 2'd0) v = K_3HALF;
                if (c == 2'd1) v = -K_3HALF;
                if (c == 2'd2 || c == 2'd3) v = K_HALF;
            end
            default: if (c == 2'd0) v = K_ONE;
        endcase
        return v;
    endfunction

    // clamp a wide signed value to 32 bits
    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > SAT_HI) begin
            r = 32'sh7FFFFFFF;
        end else if (v < SAT_LO) begin
            r = 32'sh80000000;
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

    // element index wrap by repeated compare and subtract of shifted depth
    function automatic logic [IDX_W-1:0] elem_wrap(input logic [IDX_W-1:0] idx,
                                                   input int unsigned depth);
        logic [IDX_W-1:0] v;
        v = idx;
        for (int k = IDX_W - 1; k >= 0; k--) begin
            if ((depth << k) < (32'd1 << IDX_W) && 32'(v) >= (depth << k)) begin
                v = v - IDX_W'(depth << k);
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- src/rksc_seq.sv -----
// microcode sequencer: step counter, control rom and conditional jumps
`default_nettype none

module rksc_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rksc_pkg::t_cond_in i_cond,
    output rksc_pkg::t_uword       o_uw
);
    import rksc_pkg::*;

    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    t_uword           uw;
    logic             hit;

    // current control word
    assign uw   = ucode_rom(r_upc);
    assign o_uw = uw;

    // jump condition
    always_comb begin
        case (uw.cond)
            C_NO_ITEM:  hit = !i_cond.item;
            C_BAD:      hit = i_cond.bad;
            C_MORE:     hit = i_cond.more;
            C_OUT_BUSY: hit = i_cond.out_busy;
            default:    hit = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        if (hit) begin
            n_upc = uw.target;
        end else if (uw.to_idle) begin
            n_upc = U_IDLE;
        end else begin
            n_upc = r_upc + UPC_W'(1);
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

`default_nettype wire

// ----- src/rksc_dp.sv -----
// datapath: shared multiplier, slope memory, accumulator and rounding
`default_nettype none

module rksc_dp #(
    parameter  int MAX_ELEMENTS = rksc_pkg::DEF_MAX_ELEMENTS,
    parameter  int MAX_STAGES   = rksc_pkg::DEF_MAX_STAGES,
    parameter  int FRAC_BITS    = rksc_pkg::DEF_FRAC_BITS,
    localparam int EW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire rksc_pkg::t_uword    i_uw,
    input  wire logic                i_opcode,
    input  wire logic [EW-1:0]       i_elem,
    input  wire logic signed [31:0]  i_new_value,
    input  wire logic signed [31:0]  i_old_value,
    input  wire logic [2:0]          i_stage_count,
    input  wire logic [3:0]          i_method,
    input  wire logic [30:0]         i_time_step,
    input  wire logic [30:0]         i_recip_time_step,
    output rksc_pkg::t_dp_stat       o_stat,
    output logic signed [31:0]       o_updated_value,
    output logic signed [31:0]       o_stage_slope
);
    import rksc_pkg::*;

    localparam int DEPTH = MAX_ELEMENTS * MAX_STAGES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int JW    = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam logic signed [PROD_W-1:0] VAL_RND  = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [PROD_W-1:0] COEF_RND = 66'sd1 <<< (COEF_FRAC - 1);

    logic [METH_W-1:0]         m_eff;
    logic [SNUM_W-1:0]         n_raw;
    logic [SNUM_W-1:0]         n_stages;
    logic                      is_final;
    logic                      bad;
    logic [SNUM_W-1:0]         lim_d;
    logic [STAT_W-1:0]         status_d;

    logic [JW-1:0]             r_j;
    logic [JW-1:0]             r_lim;
    logic [STAT_W-1:0]         r_status;

    logic signed [32:0]        mul_a;
    logic signed [32:0]        mul_b;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [PROD_W-1:0]  r_acc;
    logic signed [31:0]        r_slope;
    logic signed [31:0]        r_rdata;
    logic signed [31:0]        r_mem [DEPTH];

    logic signed [31:0]        coef;
    logic signed [PROD_W-1:0]  val_rnd;
    logic signed [31:0]        slope_sat;
    logic signed [PROD_W-1:0]  w_rnd;
    logic signed [31:0]        w_sat;
    logic signed [PROD_W-1:0]  old_ext;
    logic signed [31:0]        upd_sat;
    logic [AW-1:0]             wr_addr;
    logic [AW-1:0]             rd_addr;

    // method, stage count and pass check
    always_comb begin
        m_eff    = (i_method > M_RK43) ? M_FEULER : i_method;
        n_raw    = method_stages(m_eff);
        n_stages = (n_raw > SNUM_W'(MAX_STAGES)) ? SNUM_W'(MAX_STAGES) : n_raw;
        is_final = (i_opcode == OP_FINAL);
        bad      = is_final ? (i_stage_count != n_stages) : (i_stage_count >= n_stages);
        lim_d    = is_final ? (n_stages - SNUM_W'(1)) : i_stage_count;
        if (!bad) begin
            status_d = ST_OK;
        end else if (is_final) begin
            status_d = ST_INCOMPLETE;
        end else begin
            status_d = ST_ALL_DONE;
        end
    end

    // term counter and status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j      <= '0;
            r_lim    <= '0;
            r_status <= ST_OK;
        end else if (i_uw.init) begin
            r_j      <= '0;
            r_lim    <= JW'(lim_d);
            r_status <= status_d;
        end else if (i_uw.acc) begin
            r_j <= r_j + JW'(1);
        end
    end

    // coefficient for the current term
    assign coef = is_final ? b_coef(m_eff, 2'(r_j))
                           : a_coef(m_eff, i_stage_count[1:0], 2'(r_j));

    // rounding shared by slope and final scaling
    assign val_rnd   = (r_prod + VAL_RND) >>> FRAC_BITS;
    assign slope_sat = sat32(val_rnd);
    assign w_rnd     = (r_acc + COEF_RND) >>> COEF_FRAC;
    assign w_sat     = sat32(w_rnd);
    assign old_ext   = {{(PROD_W - 32){i_old_value[31]}}, i_old_value};
    assign upd_sat   = sat32(old_ext + val_rnd);

    // multiplier operand select
    always_comb begin
        case (i_uw.mop)
            MOP_SLOPE: begin
                mul_a = {i_new_value[31], i_new_value} - {i_old_value[31], i_old_value};
                mul_b = {2'b00, i_recip_time_step};
            end
            MOP_COEF: begin
                mul_a = {coef[31], coef};
                mul_b = {r_rdata[31], r_rdata};
            end
            MOP_DT: begin
                mul_a = {w_sat[31], w_sat};
                mul_b = {2'b00, i_time_step};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // registered product
    always_ff @(posedge i_clk) begin
        if (i_uw.mop != MOP_NONE) begin
            r_prod <= mul_a * mul_b;
        end
    end

    // accumulator and slope register
    always_ff @(posedge i_clk) begin
        if (i_uw.init) begin
            r_acc <= '0;
        end else if (i_uw.acc) begin
            r_acc <= r_acc + r_prod;
        end
        if (i_uw.wr_slope) begin
            r_slope <= is_final ? 32'sd0 : slope_sat;
        end
    end

    // slope memory addresses
    assign wr_addr = AW'(int'(i_elem) * MAX_STAGES + int'(i_stage_count));
    assign rd_addr = AW'(int'(i_elem) * MAX_STAGES + int'(r_j));

    // slope memory write
    always_ff @(posedge i_clk) begin
        if (i_uw.wr_slope && !is_final) begin
            r_mem[wr_addr] <= slope_sat;
        end
    end

    // slope memory read
    always_ff @(posedge i_clk) begin
        if (i_uw.rd) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // result fields
    assign o_updated_value = (r_status == ST_OK) ? upd_sat : 32'sd0;
    assign o_stage_slope   = (r_status == ST_OK) ? r_slope : 32'sd0;
    assign o_stat          = '{bad: bad, more: (r_j != r_lim), status: r_status};

endmodule

`default_nettype wire

// ----- src/runge_kutta_stage_combiner_top.sv -----
// Runge-Kutta stage combiner: per-element stage and final updates from a built-in tableau
//
// Input channel (i_in_valid/o_in_ready/i_in_beat) takes one element per beat: a stage pass
// stores the slope (new-old)/dt and returns old + dt*sum a(s,j)*slope_j, a final pass
// returns old + dt*sum b_k*slope_k. Results leave on o_out_valid/i_out_ready/o_out_beat.
// Configuration writes (method, time_step, recip_time_step) use i_cfg_valid/o_cfg_ready
// and are always taken; write them only while no beat is in flight.
// One shared 33x33 multiplier runs the slope, each coefficient term and the dt scale,
// so a beat with k terms (stage s: k = s+1, final pass: k = stage count of the method)
// runs the check, slope write, a read, multiply and accumulate per term, the dt scale and
// the result step before the next beat is taken; a refused beat goes from check to error.
// The output register holds one result; while the receiver stalls the sequencer waits
// in its last step and takes no new beat.
// Reset clears the stage count and loads method 0 and dt = 1/dt = 1.0. The slope memory
// is not cleared and needs no clearing pass; a stage pass always writes before reading.
`default_nettype none

module runge_kutta_stage_combiner_top #(
    parameter int MAX_ELEMENTS = rksc_pkg::DEF_MAX_ELEMENTS,
    parameter int MAX_STAGES   = rksc_pkg::DEF_MAX_STAGES,
    parameter int FRAC_BITS    = rksc_pkg::DEF_FRAC_BITS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire rksc_pkg::t_in_beat                 i_in_beat,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output rksc_pkg::t_out_beat                     o_out_beat,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [rksc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [rksc_pkg::DT_W-1:0]          i_cfg_data
);
    import rksc_pkg::*;

`include "runge_kutta_stage_combiner_top_defines.svh"

    localparam int EW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    logic [METH_W-1:0]       r_method;
    logic [DT_W-1:0]         r_time_step;
    logic [DT_W-1:0]         r_recip_time_step;
    logic [SNUM_W-1:0]       r_stage_count;

    logic                    r_opcode;
    logic [EW-1:0]           r_elem;
    logic signed [VAL_W-1:0] r_new_value;
    logic signed [VAL_W-1:0] r_old_value;
    logic                    r_last;

    logic                    r_out_valid;
    t_out_beat               r_out_beat;

    t_uword                  uw;
    t_cond_in                cond_in;
    t_dp_stat                dp_stat;
    logic signed [VAL_W-1:0] dp_updated;
    logic signed [VAL_W-1:0] dp_slope;
    logic                    in_acc;
    logic                    out_busy;
    logic                    out_load;

    // handshake decode
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = uw.take;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_busy    = r_out_valid && !i_out_ready;
    assign out_load    = uw.emit && !out_busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method          <= M_FEULER;
            r_time_step       <= 31'd65536;
            r_recip_time_step <= 31'd65536;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_METHOD:     r_method          <= i_cfg_data[METH_W-1:0];
                REG_TIME_STEP:  r_time_step       <= i_cfg_data;
                REG_RECIP_STEP: r_recip_time_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input beat capture
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_opcode    <= i_in_beat.opcode;
            r_elem      <= EW'(elem_wrap(i_in_beat.element_index, MAX_ELEMENTS));
            r_new_value <= i_in_beat.new_value;
            r_old_value <= i_in_beat.old_value;
            r_last      <= i_in_beat.last_element;
        end
    end

    // stage count advance, or clear after a final pass, on a good last element
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_count <= '0;
        end else if (out_load && dp_stat.status == ST_OK && r_last) begin
            r_stage_count <= (r_opcode == OP_FINAL) ? '0 : r_stage_count + SNUM_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_beat <= '{updated_value: dp_updated, stage_slope: dp_slope,
                            status: dp_stat.status, stage_number: r_stage_count};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // sequencer conditions
    assign cond_in = '{item: i_in_valid, bad: dp_stat.bad, more: dp_stat.more,
                       out_busy: out_busy};

    rksc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (cond_in),
        .o_uw    (uw)
    );

    rksc_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .MAX_STAGES   (MAX_STAGES),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_uw              (uw),
        .i_opcode          (r_opcode),
        .i_elem            (r_elem),
        .i_new_value       (r_new_value),
        .i_old_value       (r_old_value),
        .i_stage_count     (r_stage_count),
        .i_method          (r_method),
        .i_time_step       (r_time_step),
        .i_recip_time_step (r_recip_time_step),
        .o_stat            (dp_stat),
        .o_updated_value   (dp_updated),
        .o_stage_slope     (dp_slope)
    );

    // checks
    `RKSC_ASSERT_IMPL(a_stage_range, 1'b1, r_stage_count <= SNUM_W'(MAX_STAGES), "stage count out of range")
    `RKSC_ASSERT_NEXT(a_busy_after_take, in_acc, !o_in_ready, "beat taken while sequencer busy")
    `RKSC_ASSERT_NEXT(a_final_clears, out_load && r_opcode == OP_FINAL && r_last && dp_stat.status == ST_OK, r_stage_count == '0, "final pass did not clear stage count")
    `RKSC_ASSERT_IMPL(a_error_zero, o_out_valid && o_out_beat.status != ST_OK, o_out_beat.updated_value == '0 && o_out_beat.stage_slope == '0, "error beat carries data")

endmodule

`default_nettype wire
